// ===== rtl/overwriting_ring_byte_buffer_macros.svh =====
`ifndef OVERWRITING_RING_BYTE_BUFFER_MACROS_SVH
`define OVERWRITING_RING_BYTE_BUFFER_MACROS_SVH

// same-cycle implication, off while reset is high
`define ORBB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define ORBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also spans reset
`define ORBB_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/orbb_pkg.sv =====
`timescale 1ns / 1ps

package orbb_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int FUNC_W  = 3;
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 8;
   localparam int MOVED_W = 8;
   localparam int FILL_W  = 7;

   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 4;

   localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LINE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SKIP  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd5;

   // internal operation codes
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_W-1:0] OP_LINE  = 3'd3;
   localparam logic [OP_W-1:0] OP_SKIP  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0]  byte_out;
      logic               byte_valid;
      logic               last;
      logic [MOVED_W-1:0] moved;
      logic [FILL_W-1:0]  fill_level;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic room2;
   } rspq_status_type;

endpackage

// ===== rtl/overwriting_ring_byte_buffer.sv =====
`timescale 1ns / 1ps

// Byte ring buffer of DEPTH entries that overwrites the oldest byte when full.
// Requests enter a two-deep command queue and results leave through a
// four-deep result queue, so both sides stall independently. Write, skip,
// clear and unknown functions give one result each, so a write stream runs
// at one item per cycle while the result queue has room. Read and peek of n
// bytes give n results from the registered store read, one per cycle while
// the result queue has room for two. Read_line first scans its k bytes one
// per cycle through the single store read port, then delivers them as a read
// does; one that finds no line gives one empty result after its scan.
// Every result carries the fill level after its command.
module overwriting_ring_byte_buffer #(
   parameter int DEPTH = orbb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [orbb_pkg::FUNC_W-1:0]   req_func,
   input  logic [orbb_pkg::DATA_W-1:0]   req_data,
   input  logic [orbb_pkg::COUNT_W-1:0]  req_count,
   output logic                          empty,
   input  logic                          pop,
   output logic [orbb_pkg::DATA_W-1:0]   rsp_byte_out,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last,
   output logic [orbb_pkg::MOVED_W-1:0]  rsp_moved,
   output logic [orbb_pkg::FILL_W-1:0]   rsp_fill_level
);

   orbb_pkg::cmd_type         cmd_head;
   logic                      cmd_valid, cmd_pop;
   orbb_pkg::rspq_status_type rspq_status;
   logic                      rsp_push;
   orbb_pkg::rsp_type         rsp_item, rsp_head;

   orbb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_func  (req_func),
      .req_data  (req_data),
      .req_count (req_count),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head)
   );

   orbb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rspq_status (rspq_status),
      .rsp_push    (rsp_push),
      .rsp_item    (rsp_item)
   );

   orbb_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .status   (rspq_status),
      .pop      (pop),
      .empty    (empty),
      .head     (rsp_head)
   );

   assign rsp_byte_out   = rsp_head.byte_out;
   assign rsp_byte_valid = rsp_head.byte_valid;
   assign rsp_last       = rsp_head.last;
   assign rsp_moved      = rsp_head.moved;
   assign rsp_fill_level = rsp_head.fill_level;

endmodule

// ===== rtl/orbb_front.sv =====
`timescale 1ns / 1ps

module orbb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [orbb_pkg::FUNC_W-1:0]         req_func,
   input  logic [orbb_pkg::DATA_W-1:0]         req_data,
   input  logic [orbb_pkg::COUNT_W-1:0]        req_count,
   input  logic                                cmd_pop,
   output logic                                cmd_valid,
   output orbb_pkg::cmd_type                   cmd_head
);

   localparam int QD    = orbb_pkg::CMDQ_DEPTH;
   localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W = $clog2(QD + 1);

   orbb_pkg::cmd_type q_ff [QD];
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   orbb_pkg::cmd_type cmd_new;
   logic              do_push, do_pop;

   // classify the request into an operation
   always_comb begin
      cmd_new.data  = req_data;
      cmd_new.count = req_count;
      case (req_func)
         orbb_pkg::FUNC_WRITE: cmd_new.op = orbb_pkg::OP_WRITE;
         orbb_pkg::FUNC_READ:  cmd_new.op = orbb_pkg::OP_READ;
         orbb_pkg::FUNC_PEEK:  cmd_new.op = orbb_pkg::OP_PEEK;
         orbb_pkg::FUNC_LINE:  cmd_new.op = orbb_pkg::OP_LINE;
         orbb_pkg::FUNC_SKIP:  cmd_new.op = orbb_pkg::OP_SKIP;
         orbb_pkg::FUNC_CLEAR: cmd_new.op = orbb_pkg::OP_CLEAR;
         default:              cmd_new.op = orbb_pkg::OP_NOP;
      endcase
   end

   assign full      = (cnt_ff == CNT_W'(QD));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_head  = q_ff[rp_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PTR_W'(QD - 1)) ? '0 : wp_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rp_in = (rp_ff == PTR_W'(QD - 1)) ? '0 : rp_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

endmodule

// ===== rtl/orbb_rspq.sv =====
`timescale 1ns / 1ps

module orbb_rspq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_push,
   input  orbb_pkg::rsp_type         rsp_item,
   output orbb_pkg::rspq_status_type status,
   input  logic                      pop,
   output logic                      empty,
   output orbb_pkg::rsp_type         head
);

   localparam int QD    = orbb_pkg::RSPQ_DEPTH;
   localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNT_W = $clog2(QD + 1);

   orbb_pkg::rsp_type q_ff [QD];
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(QD));
   assign status.room2 = (cnt_ff <= CNT_W'(QD - 2));
   assign empty        = (cnt_ff == '0);
   assign head         = q_ff[rp_ff];
   assign do_push      = rsp_push && !status.full;
   assign do_pop       = pop && !empty;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == PTR_W'(QD - 1)) ? '0 : wp_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rp_in = (rp_ff == PTR_W'(QD - 1)) ? '0 : rp_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= rsp_item;
      end
   end

endmodule

// ===== rtl/orbb_back.sv =====
`timescale 1ns / 1ps

module orbb_back #(
   parameter int DEPTH = orbb_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  orbb_pkg::cmd_type         cmd_head,
   output logic                      cmd_pop,
   input  orbb_pkg::rspq_status_type rspq_status,
   output logic                      rsp_push,
   output orbb_pkg::rsp_type         rsp_item
);

   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_FAIL = 2'd3;

   function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p);
      return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
   endfunction

   function automatic logic [IW-1:0] adv(input logic [IW-1:0] p, input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(k);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IW-1:0];
   endfunction

   logic [orbb_pkg::DATA_W-1:0] byte_store_ff [DEPTH];
   logic [orbb_pkg::DATA_W-1:0] rd_data_ff;
   logic                        rd_vld_ff;
   logic                        rd_en, wr_en;
   logic [IW-1:0]               rd_addr;

   logic [1:0]       state_ff, state_in;
   logic [IW-1:0]    wi_ff, wi_in, ri_ff, ri_in;
   logic [CNT_W-1:0] held_ff, held_in;

   logic [IW-1:0]               sc_ptr_ff, sc_ptr_in;
   logic [CNT_W-1:0]            sc_cnt_ff, sc_cnt_in, sc_n_ff, sc_n_in;
   logic [orbb_pkg::COUNT_W-1:0] sc_count_ff, sc_count_in;

   logic [IW-1:0]    em_ptr_ff, em_ptr_in;
   logic [CNT_W-1:0] em_left_ff, em_left_in, em_total_ff, em_total_in;
   logic [CNT_W-1:0] em_sent_ff, em_sent_in;

   logic [CNT_W-1:0]             n_req, cnt1;
   logic [orbb_pkg::MOVED_W-1:0] moved;
   logic                         is_nl, is_last;

   assign n_req = (cmd_head.count > orbb_pkg::COUNT_W'(held_ff))
                  ? held_ff : cmd_head.count[CNT_W-1:0];
   assign cnt1    = sc_cnt_ff + CNT_W'(1);
   assign is_nl   = (rd_data_ff == orbb_pkg::NEWLINE_BYTE);
   assign is_last = (em_sent_ff + CNT_W'(1) == em_total_ff);

   always_comb begin
      state_in    = state_ff;
      wi_in       = wi_ff;
      ri_in       = ri_ff;
      held_in     = held_ff;
      sc_ptr_in   = sc_ptr_ff;
      sc_cnt_in   = sc_cnt_ff;
      sc_n_in     = sc_n_ff;
      sc_count_in = sc_count_ff;
      em_ptr_in   = em_ptr_ff;
      em_left_in  = em_left_ff;
      em_total_in = em_total_ff;
      em_sent_in  = em_sent_ff;
      rd_en       = 1'b0;
      rd_addr     = ri_ff;
      wr_en       = 1'b0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      moved       = '0;
      rsp_item.byte_out   = '0;
      rsp_item.byte_valid = 1'b0;
      rsp_item.last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rspq_status.full) begin
               cmd_pop = 1'b1;
               case (cmd_head.op)
                  orbb_pkg::OP_WRITE: begin
                     wr_en    = 1'b1;
                     wi_in    = nxt(wi_ff);
                     rsp_push = 1'b1;
                     moved    = orbb_pkg::MOVED_W'(1);
                     if (held_ff == CNT_W'(DEPTH)) begin
                        ri_in = nxt(wi_ff);
                     end else begin
                        held_in = held_ff + CNT_W'(1);
                     end
                  end
                  orbb_pkg::OP_READ, orbb_pkg::OP_PEEK: begin
                     if (n_req == '0) begin
                        rsp_push = 1'b1;
                     end else begin
                        if (cmd_head.op == orbb_pkg::OP_READ) begin
                           ri_in   = adv(ri_ff, n_req);
                           held_in = held_ff - n_req;
                        end
                        em_ptr_in   = ri_ff;
                        em_left_in  = n_req;
                        em_total_in = n_req;
                        em_sent_in  = '0;
                        state_in    = S_EMIT;
                     end
                  end
                  orbb_pkg::OP_LINE: begin
                     if (held_ff == '0) begin
                        rsp_push = 1'b1;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = ri_ff;
                        sc_ptr_in   = nxt(ri_ff);
                        sc_cnt_in   = '0;
                        sc_n_in     = n_req;
                        sc_count_in = cmd_head.count;
                        state_in    = S_SCAN;
                     end
                  end
                  orbb_pkg::OP_SKIP: begin
                     ri_in    = adv(ri_ff, n_req);
                     held_in  = held_ff - n_req;
                     rsp_push = 1'b1;
                     moved    = orbb_pkg::MOVED_W'(n_req);
                  end
                  orbb_pkg::OP_CLEAR: begin
                     wi_in    = '0;
                     ri_in    = '0;
                     held_in  = '0;
                     rsp_push = 1'b1;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               sc_cnt_in = cnt1;
               if (is_nl || cnt1 >= sc_n_ff) begin
                  if (is_nl || orbb_pkg::COUNT_W'(cnt1) == sc_count_ff) begin
                     ri_in       = adv(ri_ff, cnt1);
                     held_in     = held_ff - cnt1;
                     em_ptr_in   = ri_ff;
                     em_left_in  = cnt1;
                     em_total_in = cnt1;
                     em_sent_in  = '0;
                     state_in    = S_EMIT;
                  end else begin
                     state_in = S_FAIL;
                  end
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = sc_ptr_ff;
                  sc_ptr_in = nxt(sc_ptr_ff);
               end
            end
         end
         S_FAIL: begin
            if (!rspq_status.full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rd_vld_ff) begin
               rsp_push            = 1'b1;
               rsp_item.byte_out   = rd_data_ff;
               rsp_item.byte_valid = 1'b1;
               rsp_item.last       = is_last;
               moved               = is_last ? orbb_pkg::MOVED_W'(em_total_ff) : '0;
               em_sent_in          = em_sent_ff + CNT_W'(1);
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
            if (em_left_ff != '0 && rspq_status.room2) begin
               rd_en      = 1'b1;
               rd_addr    = em_ptr_ff;
               em_ptr_in  = nxt(em_ptr_ff);
               em_left_in = em_left_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_item.moved      = moved;
      rsp_item.fill_level = orbb_pkg::FILL_W'(held_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wi_ff     <= '0;
         ri_ff     <= '0;
         held_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wi_ff     <= wi_in;
         ri_ff     <= ri_in;
         held_ff   <= held_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      sc_ptr_ff   <= sc_ptr_in;
      sc_cnt_ff   <= sc_cnt_in;
      sc_n_ff     <= sc_n_in;
      sc_count_ff <= sc_count_in;
      em_ptr_ff   <= em_ptr_in;
      em_left_ff  <= em_left_in;
      em_total_ff <= em_total_in;
      em_sent_ff  <= em_sent_in;
   end

   // byte store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store_ff[wi_ff] <= cmd_head.data;
      end
      if (rd_en) begin
         rd_data_ff <= byte_store_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/orbb_checker.sv =====
`timescale 1ns / 1ps

`include "overwriting_ring_byte_buffer_macros.svh"

module orbb_checker #(
   parameter int DEPTH = orbb_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [orbb_pkg::DATA_W-1:0]   rsp_byte_out,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last,
   input logic [orbb_pkg::MOVED_W-1:0]  rsp_moved,
   input logic [orbb_pkg::FILL_W-1:0]   rsp_fill_level
);

   `ORBB_ASSERT_RESET(a_reset_idle, reset, empty && !full, "queues not idle after reset")
   `ORBB_ASSERT_IMPL(a_empty_result, !empty && !rsp_byte_valid,
      rsp_byte_out == '0 && rsp_last, "item without byte is not a zero last item")
   `ORBB_ASSERT_IMPL(a_moved_on_last, !empty && !rsp_last,
      rsp_moved == '0 && rsp_byte_valid, "moved set before last item")
   `ORBB_ASSERT_IMPL(a_fill_bound, !empty,
      rsp_fill_level <= orbb_pkg::FILL_W'(DEPTH), "fill level above depth")
   `ORBB_ASSERT_NEXT(a_hold_stalled, !empty && !pop,
      !empty && $stable(rsp_byte_out) && $stable(rsp_moved) && $stable(rsp_fill_level),
      "stalled item changed")

endmodule

bind overwriting_ring_byte_buffer orbb_checker #(.DEPTH(DEPTH)) u_orbb_checker (.*);

// ===== sim/tb_overwriting_ring_byte_buffer.sv =====
`timescale 1ns / 1ps

module tb_overwriting_ring_byte_buffer;
   import orbb_pkg::*;

   localparam int DEPTH = DEPTH_DEFAULT;
   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 2;
   localparam int RANDOM_ITEMS = 360;
   localparam int CALM_TAIL = 60;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int PRINT_CAP = 60;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   class ring_byte_tracker;
      logic [DATA_W-1:0] store [DEPTH];
      logic [5:0] wr_slot;
      logic [5:0] rd_slot;
      logic [FILL_W-1:0] held;
      rsp_type pending_rsps [$];
      int errors;
      int rsps_checked;
      int overwrites;
      int lines_taken;
      int lines_missed;

      function new();
         wr_slot = '0;
         rd_slot = '0;
         held = '0;
         errors = 0;
         rsps_checked = 0;
         overwrites = 0;
         lines_taken = 0;
         lines_missed = 0;
      endfunction

      function logic [5:0] next_slot(logic [5:0] s);
         return (s == 6'(DEPTH - 1)) ? 6'd0 : s + 6'd1;
      endfunction

      function void add_rsp(logic [DATA_W-1:0] b, logic valid, logic fin,
                            logic [MOVED_W-1:0] moved);
         rsp_type r;
         r.byte_out = valid ? b : '0;
         r.byte_valid = valid;
         r.last = fin;
         r.moved = fin ? moved : '0;
         r.fill_level = held;
         pending_rsps.push_back(r);
      endfunction

      // fill level must already hold its final value
      function void emit_run(logic [5:0] start, int unsigned n);
         logic [5:0] p;
         p = start;
         if (n == 0) begin
            add_rsp('0, 1'b0, 1'b1, '0);
         end else begin
            for (int unsigned i = 0; i < n; i++) begin
               add_rsp(store[p], 1'b1, i + 1 == n, MOVED_W'(n));
               p = next_slot(p);
            end
         end
      endfunction

      function void note_item(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] d,
                              logic [COUNT_W-1:0] c);
         int unsigned n;
         int unsigned scanned;
         logic [5:0] start;
         logic [5:0] p;
         logic [DATA_W-1:0] b;
         n = (c > held) ? held : c;
         start = rd_slot;
         case (f)
            FUNC_WRITE: begin
               store[wr_slot] = d;
               wr_slot = next_slot(wr_slot);
               if (held >= DEPTH) begin
                  held = FILL_W'(DEPTH);
                  rd_slot = wr_slot;
                  overwrites++;
               end else begin
                  held++;
               end
               add_rsp('0, 1'b0, 1'b1, 8'd1);
            end
            FUNC_READ: begin
               for (int unsigned i = 0; i < n; i++) rd_slot = next_slot(rd_slot);
               held -= FILL_W'(n);
               emit_run(start, n);
            end
            FUNC_PEEK: begin
               emit_run(start, n);
            end
            FUNC_LINE: begin
               if (held == 0) begin
                  add_rsp('0, 1'b0, 1'b1, '0);
                  lines_missed++;
               end else begin
                  scanned = 0;
                  p = rd_slot;
                  do begin
                     b = store[p];
                     p = next_slot(p);
                     scanned++;
                  end while (b != NEWLINE_BYTE && scanned < n);
                  if (scanned != c && b != NEWLINE_BYTE) begin
                     add_rsp('0, 1'b0, 1'b1, '0);
                     lines_missed++;
                  end else begin
                     rd_slot = p;
                     held -= FILL_W'(scanned);
                     emit_run(start, scanned);
                     lines_taken++;
                  end
               end
            end
            FUNC_SKIP: begin
               for (int unsigned i = 0; i < n; i++) rd_slot = next_slot(rd_slot);
               held -= FILL_W'(n);
               add_rsp('0, 1'b0, 1'b1, MOVED_W'(n));
            end
            FUNC_CLEAR: begin
               wr_slot = '0;
               rd_slot = '0;
               held = '0;
               add_rsp('0, 1'b0, 1'b1, '0);
            end
            default: begin
               add_rsp('0, 1'b0, 1'b1, '0);
            end
         endcase
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
         end
      endfunction

      function void check_item(rsp_type got);
         rsp_type want;
         rsps_checked++;
         if (pending_rsps.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: item with nothing expected, expected none, got %p",
                        $time, got);
         end else begin
            want = pending_rsps.pop_front();
            check_field("byte_out", want.byte_out, got.byte_out);
            check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            check_field("last", 8'(want.last), 8'(got.last));
            check_field("moved", want.moved, got.moved);
            check_field("fill_level", 8'(want.fill_level), 8'(got.fill_level));
         end
      endfunction

      function int pending();
         return pending_rsps.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic [FUNC_W-1:0] req_func;
   logic [DATA_W-1:0] req_data;
   logic [COUNT_W-1:0] req_count;
   logic empty;
   logic pop;
   logic [DATA_W-1:0] rsp_byte_out;
   logic rsp_byte_valid;
   logic rsp_last;
   logic [MOVED_W-1:0] rsp_moved;
   logic [FILL_W-1:0] rsp_fill_level;
   rsp_type rsp_seen;

   ring_byte_tracker tracker = new();
   logic calm;
   int items_sent;
   int sink_hold;
   int cycles;

   overwriting_ring_byte_buffer #(.DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_func(req_func),
      .req_data(req_data),
      .req_count(req_count),
      .empty(empty),
      .pop(pop),
      .rsp_byte_out(rsp_byte_out),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_last(rsp_last),
      .rsp_moved(rsp_moved),
      .rsp_fill_level(rsp_fill_level)
   );

   assign rsp_seen = {rsp_byte_out, rsp_byte_valid, rsp_last, rsp_moved, rsp_fill_level};

   initial begin
      clock = 1'b0;
   end

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) tracker.check_item(rsp_seen);
   end

   // result side, random stall bursts unless calm
   initial begin
      sink_hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (sink_hold > 0) sink_hold--;
         else if (!calm && $urandom_range(0, 9) == 0) sink_hold = $urandom_range(1, 13);
         pop <= (sink_hold == 0);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: cycle limit reached with %0d items outstanding", $time,
               tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_item(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] d,
                            logic [COUNT_W-1:0] c);
      if (!calm && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_func <= f;
      req_data <= d;
      req_count <= c;
      push <= 1'b1;
      do @(posedge clock); while (full);
      tracker.note_item(f, d, c);
      items_sent++;
   endtask

   function automatic logic [DATA_W-1:0] random_byte();
      return ($urandom_range(0, 5) == 0) ? NEWLINE_BYTE : DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return COUNT_W'($urandom_range(0, 12));
      if (r < 8) return COUNT_W'($urandom_range(0, 255));
      if (r == 8) return COUNT_W'(tracker.held);
      return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
   endfunction

   task automatic send_command();
      int unsigned r;
      logic [FUNC_W-1:0] f;
      r = $urandom_range(0, 99);
      if (r < 25) f = FUNC_READ;
      else if (r < 45) f = FUNC_PEEK;
      else if (r < 75) f = FUNC_LINE;
      else if (r < 88) f = FUNC_SKIP;
      else if (r < 94) f = FUNC_CLEAR;
      else if (r < 97) f = FUNC_SPARE_LO;
      else f = FUNC_SPARE_HI;
      send_item(f, DATA_W'($urandom_range(0, 255)), random_count());
   endtask

   initial begin
      int burst;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_func = FUNC_WRITE;
      req_data = '0;
      req_count = '0;
      calm = 1'b0;
      items_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(FUNC_CLEAR, 8'hFF, 8'hFF);
      send_item(FUNC_LINE, 8'h00, 8'd4);
      send_item(FUNC_READ, 8'h00, 8'd5);
      send_item(FUNC_WRITE, 8'h00, 8'h00);
      send_item(FUNC_WRITE, 8'hFF, 8'hFF);
      send_item(FUNC_WRITE, NEWLINE_BYTE, 8'h00);
      send_item(FUNC_WRITE, 8'h41, 8'h00);
      send_item(FUNC_PEEK, 8'h00, 8'd0);
      send_item(FUNC_PEEK, 8'h00, 8'd255);
      send_item(FUNC_LINE, 8'h00, 8'd0);
      send_item(FUNC_LINE, 8'h00, 8'd2);
      send_item(FUNC_LINE, 8'h00, 8'd0);
      send_item(FUNC_LINE, 8'h00, 8'd5);
      send_item(FUNC_SKIP, 8'h00, 8'd255);
      send_item(FUNC_SPARE_LO, 8'hA5, 8'h5A);
      send_item(FUNC_SPARE_HI, 8'h5A, 8'hA5);
      send_item(FUNC_WRITE, 8'h55, 8'h00);
      send_item(FUNC_SKIP, 8'h00, 8'd0);
      send_item(FUNC_READ, 8'h00, 8'd255);
      send_item(FUNC_CLEAR, 8'h00, 8'h00);

      // a full wrap first, then write bursts mixed with commands
      repeat (DEPTH + 8) send_item(FUNC_WRITE, random_byte(), random_count());
      send_item(FUNC_PEEK, 8'h00, 8'd255);
      while (items_sent < RANDOM_ITEMS) begin
         calm = (items_sent >= RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 16)
                                              : $urandom_range(1, 12);
         repeat (burst) send_item(FUNC_WRITE, random_byte(), random_count());
         repeat ($urandom_range(1, 5)) send_command();
      end
      push <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d overwrites of the oldest byte",
               items_sent, tracker.rsps_checked, tracker.overwrites);
      $display("line reads: %0d delivered, %0d without a line", tracker.lines_taken,
               tracker.lines_missed);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
